/* rtl/bmva_pkg.sv */
package bmva_pkg;

    localparam int KIND_W     = 2;
    localparam int ROW_W      = 5;
    localparam int COLUMN_W   = 8;
    localparam int VALUE_W    = 32;
    localparam int ROWS_CFG_W = 6;
    localparam int COLS_CFG_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COLS_CFG_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_WEIGHT  = 2'd0,
        KIND_PRELOAD = 2'd1,
        KIND_ELEMENT = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_IN_USE = 1'b0,
        CFG_COLS_IN_USE = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [ROW_W-1:0]           row;
        logic [COLUMN_W-1:0]        column;
        logic                       sign_bit;
        logic signed [VALUE_W-1:0]  preload_value;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]           out_row;
        logic signed [VALUE_W-1:0]  out_value;
        logic                       out_last;
    } t_out_item;

endpackage

/* rtl/bmva_stream_if.sv */
interface bmva_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/binary_matrix_vector_accumulate_core.sv */
// Binary matrix-vector accumulate engine.
// Input channel i_item carries weight writes, row preloads and vector
// elements; output channel o_result carries one result per active row.
// Config (rows_in_use, cols_in_use) is written on i_cfg_we; the user must
// write it only while idle, as the block itself does not enforce this.
// Weights sit in a column-wide memory: one word of ROWS bits per column,
// read at the column of the next element.
// Throughput: weight writes, preloads and elements are taken one per cycle
// while the input is open. The element that completes a vector closes the
// input in ST_DRAIN while its update lands, then ST_EMIT reads the rows out
// of the sum registers into the output register one per cycle unless the
// receiver stalls; the input reopens when the last result is loaded into the
// output register, so new items are taken while that result still waits.
// A stalled receiver holds the current result and pauses the read-out.
// Reset clears the row sums, the element count and the output valid flag and
// sets rows_in_use to 32 and cols_in_use to 256; weights hold whatever
// they held and must be written before use. No clearing pass is needed.
module binary_matrix_vector_accumulate_core
    import bmva_pkg::*;
#(
    parameter int ROWS = 32,
    parameter int COLS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bmva_stream_if.sink           i_item,
    bmva_stream_if.source         o_result
);

    localparam int RI = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CI = (COLS > 1) ? $clog2(COLS) : 1;

    logic [ROWS_CFG_W-1:0] r_rows_cfg;
    logic [COLS_CFG_W-1:0] r_cols_cfg;
    logic [ROWS_CFG_W-1:0] eff_rows;
    logic [COLS_CFG_W-1:0] eff_cols;

    logic [ROWS-1:0]    r_wmem [COLS];
    logic [ROWS-1:0]    r_wword;
    logic               r_ubit;
    logic               r_upd;
    logic [VALUE_W-1:0] r_sum [ROWS];
    logic [COLS_CFG_W-1:0] r_cnt;
    logic [RI-1:0]      r_idx;
    t_state             r_state;
    t_state             n_state;
    logic               r_ovalid;
    t_out_item          r_opay;

    t_in_item              pay;
    logic                  in_acc;
    logic                  is_w;
    logic                  is_p;
    logic                  is_e;
    logic [COLS_CFG_W-1:0] cnt_inc;
    logic                  done;
    logic [CI-1:0]         rd_col;
    logic                  load;
    logic                  idx_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= 6'd32;
            r_cols_cfg <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS_IN_USE: r_rows_cfg <= i_cfg_data[ROWS_CFG_W-1:0];
                CFG_COLS_IN_USE: r_cols_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // out-of-range settings clamp to the array
    always_comb begin
        eff_rows = r_rows_cfg;
        if (r_rows_cfg == '0) eff_rows = 6'd1;
        else if (32'(r_rows_cfg) > ROWS) eff_rows = ROWS_CFG_W'(ROWS);
        eff_cols = r_cols_cfg;
        if (r_cols_cfg == '0) eff_cols = 9'd1;
        else if (32'(r_cols_cfg) > COLS) eff_cols = COLS_CFG_W'(COLS);
    end

    assign pay    = i_item.payload;
    assign in_acc = i_item.valid && i_item.ready;
    assign is_w   = in_acc && (pay.kind == KIND_WEIGHT) && (32'(pay.row) < ROWS)
                    && (32'(pay.column) < COLS);
    assign is_p   = in_acc && (pay.kind == KIND_PRELOAD) && (32'(pay.row) < ROWS);
    assign is_e   = in_acc && (pay.kind == KIND_ELEMENT);

    assign cnt_inc = r_cnt + 9'd1;
    assign done    = cnt_inc >= eff_cols;
    assign rd_col  = (32'(r_cnt) >= COLS) ? CI'(COLS - 1) : CI'(r_cnt);

    assign idx_last = (7'(r_idx) + 7'd1) == 7'(eff_rows);

    // weight memory: bit write per item, one column word read per element
    always_ff @(posedge i_clk) begin
        if (is_w) r_wmem[CI'(pay.column)][RI'(pay.row)] <= pay.sign_bit;
        if (is_e) begin
            r_wword <= r_wmem[rd_col];
            r_ubit  <= pay.sign_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_upd <= is_e;
            if (is_e) r_cnt <= done ? '0 : cnt_inc;
        end
    end

    // a preload right after an element lands on the same edge and wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) r_sum[r] <= '0;
        end else begin
            for (int r = 0; r < ROWS; r++) begin
                if (is_p && (int'(pay.row) == r)) begin
                    r_sum[r] <= pay.preload_value;
                end else if (r_upd && (r < int'(eff_rows))) begin
                    r_sum[r] <= r_sum[r] + ((r_wword[r] == r_ubit) ?
                                            32'd1 : 32'hFFFF_FFFF);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_ACCEPT;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state      = r_state;
        i_item.ready = 1'b0;
        load         = 1'b0;
        case (r_state)
            ST_ACCEPT: begin
                i_item.ready = 1'b1;
                if (i_item.valid && (pay.kind == KIND_ELEMENT) && done)
                    n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_ovalid || o_result.ready) begin
                    load = 1'b1;
                    if (idx_last) n_state = ST_ACCEPT;
                end
            end
            default: n_state = ST_ACCEPT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_DRAIN) r_idx <= '0;
            else if (load)           r_idx <= r_idx + 1'b1;
            if (load)                 r_ovalid <= 1'b1;
            else if (o_result.ready)  r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_opay.out_row   <= ROW_W'(r_idx);
            r_opay.out_value <= r_sum[r_idx];
            r_opay.out_last  <= idx_last;
        end
    end

    assign o_result.valid   = r_ovalid;
    assign o_result.payload = r_opay;

endmodule

/* rtl/bmva_checker.sv */
module bmva_checker
    import bmva_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_payload
);

    // a result waiting under stall stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("result dropped or changed while stalled");

    // input stays closed during a read-out burst
    a_in_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_payload.out_last |-> !i_in_ready)
        else $error("input open while read-out in progress");

    // rows of a burst follow each other back to back
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_payload.out_last |=>
            i_out_valid && (i_out_payload.out_row == ROW_W'($past(i_out_payload.out_row) + 1'b1)))
        else $error("read-out skipped or broke off");

    // a burst starts at row zero after the last of the previous one
    a_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> (i_out_payload.out_row == '0))
        else $error("burst did not start at row zero");

endmodule

bind binary_matrix_vector_accumulate_core bmva_checker u_bmva_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_payload (o_result.payload)
);

/* sim/bmva_result_checker.sv */
`timescale 1ns / 1ps

module bmva_result_checker
    import bmva_pkg::*;
#(
    parameter int ROWS = 32,
    parameter int COLS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bmva_stream_if                i_item,
    bmva_stream_if                i_result,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_result_count
);

    bit                    weight_bit [ROWS][COLS];
    logic [VALUE_W-1:0]    row_sum [ROWS];
    logic [COLS_CFG_W-1:0] elem_count;
    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    t_out_item             expected_results [$];
    int                    mismatches;
    int                    results_seen;

    task automatic report_mismatch(input string msg);
        mismatches++;
        // keep the log short when the core is badly off
        if (mismatches <= 40) begin
            $display("[%0t] result %0d: %s", $time, results_seen, msg);
        end
    endtask

    task automatic predict_item(input t_in_item it);
        int        nrows;
        int        ncols;
        int        col;
        t_out_item res;
        case (it.kind)
            KIND_WEIGHT: begin
                if (it.row < ROWS && it.column < COLS) begin
                    weight_bit[it.row][it.column] = it.sign_bit;
                end
            end
            KIND_PRELOAD: begin
                if (it.row < ROWS) begin
                    row_sum[it.row] = it.preload_value;
                end
            end
            KIND_ELEMENT: begin
                nrows = (rows_reg == 0) ? 1 : (rows_reg > ROWS) ? ROWS : rows_reg;
                ncols = (cols_reg == 0) ? 1 : (cols_reg > COLS) ? COLS : cols_reg;
                col   = (elem_count >= COLS) ? COLS - 1 : elem_count;
                for (int r = 0; r < nrows; r++) begin
                    // xnor of weight and element: +1 on a match, -1 otherwise
                    row_sum[r] = row_sum[r] +
                        ((weight_bit[r][col] == it.sign_bit) ? 32'd1 : 32'hFFFF_FFFF);
                end
                elem_count = elem_count + 1'b1;
                if (elem_count >= ncols) begin
                    elem_count = '0;
                    for (int r = 0; r < nrows; r++) begin
                        res.out_row   = r[ROW_W-1:0];
                        res.out_value = row_sum[r];
                        res.out_last  = (r == nrows - 1);
                        expected_results.push_back(res);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        results_seen++;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("row %0d value %h arrived with nothing predicted",
                                      got.out_row, got.out_value));
        end else begin
            want = expected_results.pop_front();
            if (got.out_row !== want.out_row) begin
                report_mismatch($sformatf("out_row %0d, expected %0d",
                                          got.out_row, want.out_row));
            end
            if (got.out_value !== want.out_value) begin
                report_mismatch($sformatf("out_value %h, expected %h (row %0d)",
                                          got.out_value, want.out_value, want.out_row));
            end
            if (got.out_last !== want.out_last) begin
                report_mismatch($sformatf("out_last %b, expected %b (row %0d)",
                                          got.out_last, want.out_last, want.out_row));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (row_sum[r]) begin
                row_sum[r] = '0;
            end
            elem_count   = '0;
            rows_reg     = 6'd32;
            cols_reg     = 9'd256;
            mismatches   = 0;
            results_seen = 0;
            expected_results.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                check_result(i_result.payload);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROWS_IN_USE: rows_reg = i_cfg_data[ROWS_CFG_W-1:0];
                    CFG_COLS_IN_USE: cols_reg = i_cfg_data[COLS_CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                predict_item(i_item.payload);
            end
        end
        o_fail_count   <= mismatches;
        o_pending      <= expected_results.size();
        o_result_count <= results_seen;
    end

endmodule

/* sim/binary_matrix_vector_accumulate_core_test.sv */
`timescale 1ns / 1ps

module binary_matrix_vector_accumulate_core_test
    import bmva_pkg::*;
;

    localparam int ROWS = 32;
    localparam int COLS = 256;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bmva_stream_if #(.t_payload(t_in_item))  item_ch ();
    bmva_stream_if #(.t_payload(t_out_item)) result_ch ();

    int fail_count;
    int pending;
    int result_count;

    // stimulus bookkeeping: which weights exist and which column is read next
    bit weight_written [ROWS][COLS];
    int rows_eff = 32;
    int cols_eff = 256;
    int next_col = 0;
    int items_sent = 0;
    int elements_sent = 0;
    int cfg_writes = 0;
    int send_gap_pct = 0;
    int stall_pct = 0;

    binary_matrix_vector_accumulate_core #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    bmva_result_checker #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) result_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_item        (item_ch),
        .i_result      (result_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input int row, input int column,
                             input logic sbit, input logic [VALUE_W-1:0] value);
        t_in_item    it;
        logic [63:0] junk;
        it.kind          = kind;
        it.row           = row[ROW_W-1:0];
        it.column        = column[COLUMN_W-1:0];
        it.sign_bit      = sbit;
        it.preload_value = value;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            junk = {$urandom, $urandom};
            item_ch.valid   <= 1'b0;
            item_ch.payload <= junk[$bits(t_in_item)-1:0];
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        @(posedge clk);
        while (!item_ch.ready) begin
            @(posedge clk);
        end
        items_sent++;
        if (kind == KIND_WEIGHT) begin
            weight_written[it.row][it.column] = 1'b1;
        end
        if (kind == KIND_ELEMENT) begin
            elements_sent++;
            next_col++;
            if (next_col >= cols_eff) begin
                next_col = 0;
            end
        end
    endtask

    // fill in any weight the next element would read before it was written
    task automatic send_element(input logic sbit);
        for (int r = 0; r < rows_eff; r++) begin
            if (!weight_written[r][next_col]) begin
                send_item(KIND_WEIGHT, r, next_col, $urandom_range(0, 1), $urandom);
            end
        end
        send_item(KIND_ELEMENT, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                  sbit, $urandom);
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
        if (idx == CFG_ROWS_IN_USE) begin
            rows_eff = (data[ROWS_CFG_W-1:0] == 0) ? 1 :
                       (data[ROWS_CFG_W-1:0] > ROWS) ? ROWS : data[ROWS_CFG_W-1:0];
        end else begin
            cols_eff = (data[COLS_CFG_W-1:0] == 0) ? 1 :
                       (data[COLS_CFG_W-1:0] > COLS) ? COLS : data[COLS_CFG_W-1:0];
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] rows_val,
                             input logic [CFG_DATA_W-1:0] cols_val,
                             input int gap, input int stall, input int n_items);
        int pick;
        write_cfg(CFG_ROWS_IN_USE, rows_val);
        write_cfg(CFG_COLS_IN_USE, cols_val);
        send_gap_pct = gap;
        stall_pct    = stall;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_element($urandom_range(0, 1));
            end else if (pick < 65) begin
                send_item(KIND_WEIGHT, $urandom_range(0, rows_eff - 1),
                          $urandom_range(0, cols_eff - 1), $urandom_range(0, 1), $urandom);
            end else if (pick < 82) begin
                // some preloads sit next to the positive wrap point, on either side of it
                send_item(KIND_PRELOAD, $urandom_range(0, ROWS - 1), $urandom_range(0, 255),
                          $urandom_range(0, 1),
                          ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFE + $urandom_range(0, 3)
                                                      : $urandom);
            end else if (pick < 94) begin
                send_item(KIND_WEIGHT, $urandom_range(0, ROWS - 1), $urandom_range(0, 255),
                          $urandom_range(0, 1), $urandom);
            end else begin
                send_item(KIND_UNUSED, $urandom_range(0, ROWS - 1), $urandom_range(0, 255),
                          $urandom_range(0, 1), $urandom);
            end
        end
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_ROWS_IN_USE;
        cfg_data          = '0;
        item_ch.valid     = 1'b0;
        item_ch.payload   = '0;
        result_ch.ready   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // three rows, two columns, sums preloaded at both wrap points
        write_cfg(CFG_ROWS_IN_USE, 9'd3);
        write_cfg(CFG_COLS_IN_USE, 9'd2);
        send_item(KIND_PRELOAD, 0, 255, 1'b1, 32'h7FFF_FFFF);
        send_item(KIND_PRELOAD, 1, 0, 1'b0, 32'h8000_0000);
        send_item(KIND_UNUSED, 31, 255, 1'b1, 32'hFFFF_FFFF);
        send_item(KIND_WEIGHT, 31, 255, 1'b1, 32'h0);
        send_item(KIND_WEIGHT, 31, 0, 1'b0, 32'hFFFF_FFFF);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 2; c++) begin
                send_item(KIND_WEIGHT, r, c, (r == 0) || (r == 2 && c == 0), $urandom);
            end
        end
        send_element(1'b1);
        send_element(1'b1);
        // preload and weight change while a vector is half streamed
        send_element(1'b0);
        send_item(KIND_PRELOAD, 2, 0, 1'b0, 32'hFFFF_FFFB);
        send_item(KIND_WEIGHT, 0, 1, 1'b0, 32'h0);
        send_element(1'b1);
        // shrink the vector length to the count already reached
        send_element(1'b1);
        write_cfg(CFG_COLS_IN_USE, 9'd1);
        send_element(1'b0);
        // zero in both registers acts as one
        write_cfg(CFG_ROWS_IN_USE, 9'd0);
        write_cfg(CFG_COLS_IN_USE, 9'd0);
        send_element(1'b1);
        send_element(1'b0);

        run_phase(9'd32, 9'd2, 0, 0, 28);
        run_phase(9'd5, 9'd7, 46, 0, 28);
        run_phase(9'h1FF, 9'd1, 0, 46, 22);
        run_phase(9'd1, 9'd0, 16, 16, 22);

        // a single row; the length register moves above the array partway
        // through a vector, then drops to zero, which closes the vector
        write_cfg(CFG_ROWS_IN_USE, 9'h1C1);
        write_cfg(CFG_COLS_IN_USE, 9'd40);
        send_gap_pct = 16;
        stall_pct    = 16;
        repeat (16) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(KIND_PRELOAD, 0, $urandom_range(0, 255), 1'b0, $urandom);
            end
            send_element($urandom_range(0, 1));
        end
        write_cfg(CFG_COLS_IN_USE, 9'h1FF);
        repeat (6) begin
            send_element($urandom_range(0, 1));
        end
        write_cfg(CFG_COLS_IN_USE, 9'd0);
        do begin
            send_element($urandom_range(0, 1));
        end while (next_col != 0);

        run_phase(9'd40, 9'd3, 0, 46, 22);
        run_phase(9'd17, 9'd2, 16, 16, 22);

        item_ch.valid <= 1'b0;
        @(posedge clk);
        for (int t = 0; t < 50000 && pending != 0; t++) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent, %0d of them vector elements, over %0d register writes",
                 items_sent, elements_sent, cfg_writes);
        $display("%0d results compared with the predicted row sums", result_count);
        if (pending != 0) begin
            $display("%0d predicted results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("binary_matrix_vector_accumulate_core test passed");
        end else begin
            $display("binary_matrix_vector_accumulate_core test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timed out waiting on the core");
        $display("binary_matrix_vector_accumulate_core test failed");
        $finish;
    end

endmodule

/* binary_matrix_vector_accumulate_core.f */
rtl/bmva_pkg.sv
rtl/bmva_stream_if.sv
rtl/binary_matrix_vector_accumulate_core.sv
rtl/bmva_checker.sv
sim/bmva_result_checker.sv
sim/binary_matrix_vector_accumulate_core_test.sv
